### design/lnf_pkg.sv
// Shared constants, types and handshake structs for the newline line framer.
package lnf_pkg;

  localparam int LINE_MAX   = 64;
  localparam int LINE_SLOTS = LINE_MAX - 1;
  localparam int LEN_W      = $clog2(LINE_MAX);
  localparam int ADDR_W     = LEN_W + 1;
  localparam int CHAR_W     = 8;
  localparam int LIMIT_W    = 7;
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
  localparam logic [CHAR_W-1:0]  LF_CODE     = 8'd10;
  localparam logic [CHAR_W-1:0]  CR_CODE     = 8'd13;

  // One finished line waiting to be emitted.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] count;
    logic             empty;
  } lnf_desc_t;

  // Release of a line bank once its last character has been emitted.
  typedef struct packed {
    logic valid;
    logic bank;
  } lnf_done_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } lnf_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } lnf_rd_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } lnf_qstat_t;

endpackage

### design/lnf_store.sv
// Two-bank line store: one write port, one read port with registered data.
module lnf_store
  import lnf_pkg::*;
(
  input  logic              clk,
  input  lnf_wr_t           wr,
  input  lnf_rd_t           rd,
  output logic [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [0:(2**ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### design/lnf_queue.sv
// Small FIFO of finished-line descriptors between the front and the back.
module lnf_queue
  import lnf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lnf_desc_t  push_desc,
  input  logic       pop,
  output lnf_desc_t  head,
  output lnf_qstat_t stat
);

  lnf_desc_t         slots [0:Q_DEPTH-1];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign head          = slots[rptr];
  assign stat.full     = (count == QCNT_W'(Q_DEPTH));
  assign stat.nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/lnf_front.sv
// Receive side: stores bytes into the current bank and closes lines on linefeed.
module lnf_front
  import lnf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  logic [CHAR_W-1:0]  rx_byte,
  input  logic [LIMIT_W-1:0] out_limit,
  input  lnf_done_t          done,
  output lnf_wr_t            wr,
  output logic               push,
  output lnf_desc_t          push_desc
);

  logic [LEN_W-1:0]   line_length;
  logic [LEN_W-1:0]   line_length_next;
  logic               last_cr;
  logic               last_cr_next;
  logic               wbank;
  logic               wbank_next;
  logic [1:0]         busy;
  logic [1:0]         busy_next;

  logic               accept;
  logic               is_lf;
  logic [LEN_W-1:0]   n_strip;
  logic [LIMIT_W-1:0] cap;
  logic [LEN_W-1:0]   copy;

  // A bank may be refilled only after the back has drained it.
  assign rx_ready = !busy[wbank];
  assign accept   = rx_valid && rx_ready;
  assign is_lf    = (rx_byte == LF_CODE);

  always_comb begin
    n_strip = line_length - LEN_W'(last_cr);
    cap     = (out_limit == '0) ? '0 : out_limit - 1'b1;
    copy    = (LIMIT_W'(n_strip) < cap) ? n_strip : cap[LEN_W-1:0];

    push            = accept && is_lf && (line_length != '0);
    push_desc.bank  = wbank;
    push_desc.count = copy;
    push_desc.empty = (copy == '0);

    wr.en   = accept && !is_lf && (line_length < LEN_W'(LINE_SLOTS));
    wr.addr = {wbank, line_length};
    wr.data = rx_byte;

    line_length_next = line_length;
    last_cr_next     = last_cr;
    wbank_next       = wbank;
    busy_next        = busy;

    if (done.valid) begin
      busy_next[done.bank] = 1'b0;
    end
    if (accept) begin
      if (is_lf) begin
        line_length_next = '0;
        last_cr_next     = 1'b0;
        if (push) begin
          busy_next[wbank] = 1'b1;
          wbank_next       = !wbank;
        end
      end else if (wr.en) begin
        line_length_next = line_length + 1'b1;
        last_cr_next     = (rx_byte == CR_CODE);
      end else begin
        // Overlong line: drop everything collected so far.
        line_length_next = '0;
        last_cr_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
      last_cr     <= 1'b0;
      wbank       <= 1'b0;
      busy        <= '0;
    end else begin
      line_length <= line_length_next;
      last_cr     <= last_cr_next;
      wbank       <= wbank_next;
      busy        <= busy_next;
    end
  end

endmodule

### design/lnf_back.sv
// Emit side: reads a finished line out of its bank into the output register.
module lnf_back
  import lnf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lnf_desc_t         head,
  input  logic              q_nonempty,
  output logic              pop,
  output lnf_rd_t           rd,
  input  logic [CHAR_W-1:0] rd_data,
  output lnf_done_t         done,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_empty,
  output logic              out_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic             state;
  logic             state_next;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] idx_next;

  logic              out_free;
  logic              load;
  logic [CHAR_W-1:0] ld_char;
  logic              ld_empty;
  logic              ld_last;

  assign out_free   = !out_valid || out_ready;
  assign done.valid = pop;
  assign done.bank  = head.bank;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    load       = 1'b0;
    ld_char    = '0;
    ld_empty   = 1'b0;
    ld_last    = 1'b0;
    pop        = 1'b0;
    rd.en      = 1'b0;
    rd.addr    = {head.bank, idx};

    unique case (state)
      ST_IDLE: begin
        if (q_nonempty) begin
          if (head.empty) begin
            if (out_free) begin
              load     = 1'b1;
              ld_empty = 1'b1;
              ld_last  = 1'b1;
              pop      = 1'b1;
            end
          end else begin
            rd.en      = 1'b1;
            rd.addr    = {head.bank, LEN_W'(0)};
            idx_next   = '0;
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          load    = 1'b1;
          ld_char = rd_data;
          ld_last = (idx == head.count - 1'b1);
          if (ld_last) begin
            pop        = 1'b1;
            state_next = ST_IDLE;
          end else begin
            // Fetch the next character while this one goes out.
            idx_next = idx + 1'b1;
            rd.en    = 1'b1;
            rd.addr  = {head.bank, idx + 1'b1};
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= ld_char;
      out_empty <= ld_empty;
      out_last  <= ld_last;
    end
  end

endmodule

### design/newline_line_framer.sv
// Top level of the newline line framer: front, descriptor queue, line store and back.
//
//  Channel   Direction  Word contents (lowest bit first)
//  s_axis    in         tdata[7:0] = rx_byte
//  m_axis    out        tdata[7:0] = line_char, tuser = empty_line, tlast = last
//  cfg       in         cfg_data[6:0] = out_limit
//
// The front takes one byte per cycle whenever the bank it is filling is free.
// A linefeed that closes a line pushes a descriptor and switches banks; the
// front stalls only while both banks hold lines still being emitted.
// For a line with characters the back first issues the store read of its first one and then moves
// one character per cycle into the output register while m_axis_tready is high.
// Reset (rst, synchronous, active high) empties the line, the queue and the
// output register and sets out_limit to 64; the store needs no clearing.
module newline_line_framer
  import lnf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte

  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [7:0] line_char
  output logic               m_axis_tuser,   // [0] empty_line
  output logic               m_axis_tlast,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data        // [6:0] out_limit
);

  logic [LIMIT_W-1:0] out_limit;

  lnf_wr_t           wr;
  lnf_rd_t           rd;
  logic [CHAR_W-1:0] rd_data;
  logic              q_push;
  lnf_desc_t         q_push_desc;
  logic              q_pop;
  lnf_desc_t         q_head;
  lnf_qstat_t        q_stat;
  lnf_done_t         done;

  // The limit register is always writable; the user must change it only while idle, as the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      out_limit <= cfg_data;
    end
  end

  lnf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (s_axis_tvalid),
    .rx_ready  (s_axis_tready),
    .rx_byte   (s_axis_tdata),
    .out_limit (out_limit),
    .done      (done),
    .wr        (wr),
    .push      (q_push),
    .push_desc (q_push_desc)
  );

  lnf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_push_desc),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  lnf_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  lnf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_nonempty (q_stat.nonempty),
    .pop        (q_pop),
    .rd         (rd),
    .rd_data    (rd_data),
    .done       (done),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (m_axis_tdata),
    .out_empty  (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

  // Bank tracking must keep the descriptor queue from ever overflowing.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("line descriptor pushed into a full queue");

  // The back only retires a line that the queue actually holds.
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.nonempty)
    else $error("line descriptor popped from an empty queue");

  // An empty-line word is always the whole run, with a zero character.
  a_empty_is_single: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("empty-line word without tlast or with nonzero data");

  // Store writes never land in a bank that the back is still reading.
  a_write_not_read_bank: assert property (@(posedge clk) disable iff (rst)
    (wr.en && rd.en) |-> (wr.addr[ADDR_W-1] != rd.addr[ADDR_W-1]))
    else $error("store write and read hit the same bank");

endmodule

### tb/sv/tb_newline_line_framer.sv
// Self-checking testbench for newline_line_framer: line traffic checked against a line predictor.
`timescale 1ns / 100ps

module tb_newline_line_framer;
  import lnf_pkg::*;

  // One expected output word of a line run.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              empty;
    logic              last;
  } line_word_t;

  // Cycles allowed after the last expected word before the block counts as idle.
  // The back needs a store read plus a register stage, so this is generous.
  localparam int SETTLE_CYCLES = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;    // [7:0] rx_byte

  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [7:0]         m_axis_tdata;         // [7:0] line_char
  logic               m_axis_tuser;         // [0] empty_line
  logic               m_axis_tlast;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;        // [6:0] out_limit

  // Predictor state: the line being collected and the current output limit.
  logic [CHAR_W-1:0]  line_buf [LINE_SLOTS];
  int unsigned        line_len = 0;
  int unsigned        limit_reg = LIMIT_RESET;

  // Bytes still to be sent, and words the block still owes us.
  logic [7:0]         rx_pending [$];
  line_word_t         line_expect [$];

  int                 fail_count = 0;
  int                 rx_gap = 0;
  int                 tx_hold = 0;
  bit                 calm = 1'b0;          // when set, neither side idles

  newline_line_framer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Predicts the words caused by one accepted byte. A linefeed closes the
  // line: an empty store gives nothing, a trailing carriage return is
  // dropped, and the rest is cut to the limit minus one. A line that ends
  // up with no characters gives a single word flagged empty. Any other byte
  // is stored, unless the store is already full, in which case the whole
  // line is thrown away along with that byte.
  function automatic void frame_rx_byte(logic [CHAR_W-1:0] b);
    int unsigned n;
    int unsigned cap;
    int unsigned copy;
    line_word_t  w;
    if (b == LF_CODE) begin
      n = line_len;
      line_len = 0;
      if (n == 0) return;
      if (line_buf[n-1] == CR_CODE) n--;
      // A limit of zero behaves like a limit of one.
      cap = (limit_reg == 0) ? 0 : limit_reg - 1;
      copy = (n < cap) ? n : cap;
      if (copy == 0) begin
        w.ch = '0;
        w.empty = 1'b1;
        w.last = 1'b1;
        line_expect.push_back(w);
      end else begin
        for (int unsigned i = 0; i < copy; i++) begin
          w.ch = line_buf[i];
          w.empty = 1'b0;
          w.last = (i + 1 == copy);
          line_expect.push_back(w);
        end
      end
    end else if (line_len < LINE_SLOTS) begin
      line_buf[line_len] = b;
      line_len++;
    end else begin
      line_len = 0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Idle length for either side: mostly none, often a short stretch, now and
  // then a long stretch.
  function automatic int pick_idle();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Any byte but a linefeed; a linefeed drawn here becomes a carriage return
  // so that carriage returns inside a line turn up often.
  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == LF_CODE) c = CR_CODE;
    return c;
  endfunction

  task automatic queue_line(int len, bit cr_end);
    for (int i = 0; i < len; i++) rx_pending.push_back(rand_char());
    if (cr_end) rx_pending.push_back(CR_CODE);
    rx_pending.push_back(LF_CODE);
  endtask

  // A mix of well-formed lines with random content, a few longer lines and
  // some raw noise that may hold stray linefeeds.
  task automatic queue_random_lines(int budget);
    int start;
    int unsigned kind;
    start = rx_pending.size();
    while (rx_pending.size() - start < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        queue_line($urandom_range(0, 12), $urandom_range(0, 2) == 0);
      end else if (kind < 85) begin
        queue_line($urandom_range(13, 40), $urandom_range(0, 1) == 1);
      end else begin
        repeat ($urandom_range(1, 6)) rx_pending.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Waits until every byte has been taken and every expected word has come
  // out, then lets the block settle so nothing is left in flight. Checks are
  // made at the falling edge, away from the driver and monitor.
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_pending.size() != 0 || s_axis_tvalid || line_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes out_limit only once the block is idle, and mirrors it into the
  // predictor at the edge where the write is taken.
  task automatic write_out_limit(logic [LIMIT_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    limit_reg = value;
    cfg_valid <= 1'b0;
  endtask

  // Byte driver. A word is taken at an edge where tvalid and tready are both
  // high; the predictor sees it at that same edge. A new word is offered only
  // once the previous one is gone, after a random idle stretch.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      rx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) frame_rx_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_gap != 0) begin
          rx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= rx_pending.pop_front();
          rx_gap = pick_idle();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Line monitor. Each word taken is matched against the oldest expected
  // word; tready is dropped for random stretches to back-pressure the block.
  always @(posedge clk) begin : tx_side
    line_word_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      tx_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (line_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected word char=%02h empty=%b last=%b",
                                    m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = line_expect.pop_front();
          if (m_axis_tuser !== want.empty)
            report_mismatch($sformatf("empty_line %b, expected %b", m_axis_tuser, want.empty));
          // On an empty-line word the character carries no meaning.
          if (!want.empty && m_axis_tdata !== want.ch)
            report_mismatch($sformatf("line_char %02h, expected %02h", m_axis_tdata, want.ch));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last %b, expected %b", m_axis_tlast, want.last));
        end
      end
      if (tx_hold != 0) begin
        tx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        tx_hold = pick_idle();
      end
    end
  end

  // Stimulus sequence: directed cases under the reset limit, then random
  // lines under a range of limits, the extremes among them.
  initial begin
    logic [7:0] directed [];
    directed = '{
      LF_CODE,                                   // linefeed on an empty store
      8'h00, 8'hFF, CR_CODE, 8'h41, LF_CODE,     // extreme bytes, inner CR kept
      CR_CODE, LF_CODE,                          // strips to an empty line
      CR_CODE, CR_CODE, LF_CODE,                 // only the final CR goes
      8'h80, 8'h7F, CR_CODE, LF_CODE,            // trailing CR stripped
      LF_CODE,                                   // empty store again
      8'h20, LF_CODE
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) rx_pending.push_back(directed[i]);
    queue_random_lines(5);

    // A limit of one leaves no room for characters, so every line is empty.
    write_out_limit(7'd1);
    queue_line(3, 1'b0);

    // Zero saturates and acts like one.
    write_out_limit(7'd0);
    queue_line(2, 1'b1);

    // Largest limit: a full-length line comes out whole. The leading
    // linefeed flushes any noise left in the store.
    write_out_limit(7'd127);
    rx_pending.push_back(LF_CODE);
    for (int i = 0; i < LINE_SLOTS - 1; i++) rx_pending.push_back(rand_char());
    rx_pending.push_back(8'h41);
    rx_pending.push_back(LF_CODE);

    // One character per line, with both sides running flat out.
    calm = 1'b1;
    write_out_limit(7'd2);
    queue_random_lines(5);

    calm = 1'b0;
    write_out_limit(7'($urandom_range(3, 63)));
    queue_random_lines(5);

    // Back to the reset limit. An overlong line is discarded together with
    // the byte that overflows it; the short tail after it forms a new line.
    write_out_limit(7'd64);
    rx_pending.push_back(LF_CODE);
    for (int i = 0; i < LINE_SLOTS + 1; i++) rx_pending.push_back(rand_char());
    queue_line(2, 1'b0);

    wait_drained();
    if (line_expect.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", line_expect.size()));
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with every idle at its longest.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
